[sv/murmur3_32_hash_core_macros.svh]
// Assertion helpers for the RTL, used by mm3_ctrl. Both sample on clk and are off while rst_n is low.
`ifndef MURMUR3_32_HASH_CORE_MACROS_SVH
`define MURMUR3_32_HASH_CORE_MACROS_SVH

// Same-cycle implication.
`define MM3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MM3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mm3_pkg.sv]
package mm3_pkg;

  localparam logic [31:0] MM3_C1        = 32'hcc9e2d51;
  localparam logic [31:0] MM3_C2        = 32'h1b873593;
  localparam logic [31:0] MM3_MIX_N     = 32'he6546b64;
  localparam logic [31:0] MM3_F1        = 32'h85ebca6b;
  localparam logic [31:0] MM3_F2        = 32'hc2b2ae35;
  localparam logic [31:0] MM3_SEED_RST  = 32'hFFFFFFFF;
  localparam logic [1:0]  MM3_PEND_FULL = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ABSORB,
    OP_TAIL_C1,
    OP_MUL_C2,
    OP_MIX_WORD,
    OP_FIN_F1,
    OP_FIN_F2,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic word_full;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WORD_C2,
    S_WORD_MIX,
    S_TAIL_C1,
    S_TAIL_C2,
    S_FIN_F1,
    S_FIN_F2,
    S_OUT
  } ctrl_state_t;

endpackage

[sv/murmur3_32_hash_core.sv]
// MurmurHash3 x86_32 engine taking one message byte per beat, seeded from the seed register
// (cfg_we/cfg_data, reset 0xFFFFFFFF; write it only between messages). A beat with
// in_byte_present low adds no byte; in_last closes the message and yields one hash beat,
// an empty message included. One 32x32 multiplier is shared by all scramble and
// finalization multiplies. A beat that completes a 4-byte word adds the C2 and mix steps, a
// closing beat the tail C1, C2, F1 and F2 steps; in_stall holds off new beats during them.
// The next message may start while the previous hash waits on out_stall.
module murmur3_32_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);
  import mm3_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mm3_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .out_hash_value  (out_hash_value)
  );

endmodule

[sv/mm3_datapath.sv]
module mm3_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  mm3_pkg::dp_cmd_t cmd,
  output mm3_pkg::dp_sts_t sts,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_data,
  input  logic [7:0]       in_data_byte,
  input  logic             in_byte_present,
  output logic [31:0]      out_hash_value
);
  import mm3_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] out_r, out_nxt;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] fin_t, mix_x, mix_h;

  assign sts.word_full = in_byte_present && (cnt_r == MM3_PEND_FULL);

  assign fin_t = hash_r ^ acc_r ^ len_r;
  assign mix_x = hash_r ^ acc_r;
  assign mix_h = {mix_x[18:0], mix_x[31:19]};

  // Single shared multiplier, low 32 bits of the product.
  always_comb begin
    mul_a = acc_r;
    mul_b = MM3_C1;
    unique case (cmd.op)
      OP_ABSORB: begin
        mul_a = {in_data_byte, pend_r};
        mul_b = MM3_C1;
      end
      OP_TAIL_C1: begin
        mul_a = {8'h00, pend_r};
        mul_b = MM3_C1;
      end
      OP_MUL_C2: begin
        mul_a = {acc_r[16:0], acc_r[31:17]};
        mul_b = MM3_C2;
      end
      OP_FIN_F1: begin
        mul_a = fin_t ^ (fin_t >> 16);
        mul_b = MM3_F1;
      end
      OP_FIN_F2: begin
        mul_a = acc_r ^ (acc_r >> 13);
        mul_b = MM3_F2;
      end
      default: begin
        mul_a = acc_r;
        mul_b = MM3_C1;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    seed_nxt   = seed_r;
    hash_nxt   = hash_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    in_msg_nxt = in_msg_r;
    acc_nxt    = acc_r;
    out_nxt    = out_r;

    if (cfg_we) begin
      seed_nxt = cfg_data;
      if (!in_msg_r) begin
        hash_nxt = cfg_data;
      end
    end

    unique case (cmd.op)
      OP_ABSORB: begin
        if (in_byte_present) begin
          in_msg_nxt = 1'b1;
          len_nxt    = len_r + 32'd1;
          unique case (cnt_r)
            2'd0: pend_nxt[7:0]   = in_data_byte;
            2'd1: pend_nxt[15:8]  = in_data_byte;
            2'd2: pend_nxt[23:16] = in_data_byte;
            default: begin
              acc_nxt  = prod;
              pend_nxt = '0;
            end
          endcase
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      OP_TAIL_C1, OP_MUL_C2, OP_FIN_F1, OP_FIN_F2: begin
        acc_nxt = prod;
      end
      OP_MIX_WORD: begin
        hash_nxt = {mix_h[29:0], 2'b00} + mix_h + MM3_MIX_N;
      end
      OP_DONE: begin
        out_nxt    = acc_r ^ (acc_r >> 16);
        hash_nxt   = seed_r;
        pend_nxt   = '0;
        cnt_nxt    = '0;
        len_nxt    = '0;
        in_msg_nxt = 1'b0;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= MM3_SEED_RST;
      hash_r   <= MM3_SEED_RST;
      pend_r   <= '0;
      cnt_r    <= '0;
      len_r    <= '0;
      in_msg_r <= 1'b0;
    end else begin
      seed_r   <= seed_nxt;
      hash_r   <= hash_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

  assign out_hash_value = out_r;

endmodule

[sv/mm3_ctrl.sv]
`include "murmur3_32_hash_core_macros.svh"

module mm3_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output mm3_pkg::dp_cmd_t cmd,
  input  mm3_pkg::dp_sts_t sts
);
  import mm3_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        accept;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd.op        = OP_NOP;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op   = OP_ABSORB;
          last_nxt = in_last;
          if (sts.word_full) begin
            state_nxt = S_WORD_C2;
          end else if (in_last) begin
            state_nxt = S_TAIL_C1;
          end
        end
      end
      S_WORD_C2: begin
        cmd.op    = OP_MUL_C2;
        state_nxt = S_WORD_MIX;
      end
      S_WORD_MIX: begin
        cmd.op    = OP_MIX_WORD;
        state_nxt = last_r ? S_TAIL_C1 : S_IDLE;
      end
      S_TAIL_C1: begin
        cmd.op    = OP_TAIL_C1;
        state_nxt = S_TAIL_C2;
      end
      S_TAIL_C2: begin
        cmd.op    = OP_MUL_C2;
        state_nxt = S_FIN_F1;
      end
      S_FIN_F1: begin
        cmd.op    = OP_FIN_F1;
        state_nxt = S_FIN_F2;
      end
      S_FIN_F2: begin
        cmd.op    = OP_FIN_F2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.op        = OP_DONE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `MM3_ASSERT_NXT(a_word_mix, accept && sts.word_full, state_r == S_WORD_C2, "full word not mixed")
  `MM3_ASSERT_NXT(a_tail_go, accept && !sts.word_full && in_last, state_r == S_TAIL_C1, "last beat not finalized")
  `MM3_ASSERT_NXT(a_out_load, state_r == S_OUT && out_free, out_valid_r, "result beat not posted")
  `MM3_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(state_r) == S_OUT, "result beat out of sequence")

endmodule

[sim/tb.sv]
module tb;
  import mm3_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 300;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {ROW_BEAT, ROW_SEED} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        known;
    logic [31:0] value;  // typed hash for a beat row, new seed for a seed row
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_hash_value;

  // typed hash that rides along with the beat that closes a directed message
  logic        known_valid;
  logic [31:0] known_hash;

  // predictor state
  logic [31:0] seed_reg;
  logic [31:0] run_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_count;
  logic [31:0] msg_len;
  logic        msg_open;

  logic [31:0] hash_expected[$];

  int gap_pct;
  int stall_pct;
  int cycle_count;
  int mismatch_count;
  int hash_checks;
  int data_beats;
  int messages;
  int seed_writes;

  stim_row_t directed_rows[] = '{
    '{ROW_BEAT, 8'h5a, 1'b0, 1'b1, 1'b1, 32'h81f16f39},
    '{ROW_SEED, 8'h00, 1'b0, 1'b0, 1'b0, 32'h00000000},
    '{ROW_BEAT, 8'hff, 1'b0, 1'b1, 1'b1, 32'h00000000},
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, 1'b1, 32'h514e28b7},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'haa, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h21, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h43, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h65, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h87, 1'b0, 1'b1, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{ROW_SEED, 8'h00, 1'b0, 1'b0, 1'b0, 32'h00000001},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b1, 1'b1, 32'h514e28b7},
    '{ROW_SEED, 8'h00, 1'b0, 1'b0, 1'b0, 32'hffffffff},
    '{ROW_BEAT, 8'h12, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BEAT, 8'h34, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  murmur3_32_hash_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash_value  (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d hashes still expected",
             cycle_count, hash_expected.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_word(input logic [31:0] w);
    logic [31:0] k;
    k = w * MM3_C1;
    k = rotl32(k, 15);
    return k * MM3_C2;
  endfunction

  function automatic logic [31:0] finish_hash(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] f;
    f = h ^ len;
    f = f ^ (f >> 16);
    f = f * MM3_F1;
    f = f ^ (f >> 13);
    f = f * MM3_F2;
    return f ^ (f >> 16);
  endfunction

  task automatic restart_message();
    run_hash   = seed_reg;
    tail_bytes = '0;
    tail_count = '0;
    msg_len    = '0;
    msg_open   = 1'b0;
  endtask

  task automatic absorb_beat(input logic [7:0] b, input logic present, input logic last,
                             input logic use_known, input logic [31:0] typed_hash);
    logic [31:0] h;
    if (present) begin
      msg_open = 1'b1;
      msg_len  = msg_len + 32'd1;
      data_beats++;
      if (tail_count == MM3_PEND_FULL) begin
        h = run_hash ^ scramble_word({b, tail_bytes});
        h = rotl32(h, 13);
        run_hash   = h * 32'd5 + MM3_MIX_N;
        tail_bytes = '0;
        tail_count = '0;
      end else begin
        tail_bytes = tail_bytes | (24'(b) << (8 * tail_count));
        tail_count = tail_count + 2'd1;
      end
    end
    if (last) begin
      h = finish_hash(run_hash ^ scramble_word({8'h00, tail_bytes}), msg_len);
      hash_expected.push_back(use_known ? typed_hash : h);
      messages++;
      restart_message();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("Mismatch (%s) at cycle %0d: expected %08h, got %08h",
               what, cycle_count, want, got);
  endtask

  // predictor and scoreboard, both sampled at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg = MM3_SEED_RST;
      restart_message();
    end else begin
      if (cfg_we) begin
        seed_reg = cfg_data;
        if (!msg_open)
          run_hash = seed_reg;
      end
      if (in_valid && !in_stall)
        absorb_beat(in_data_byte, in_byte_present, in_last, known_valid, known_hash);
      if (out_valid && !out_stall) begin
        hash_checks++;
        if (hash_expected.size() == 0)
          note_mismatch("no hash expected", 32'h0, out_hash_value);
        else if (hash_expected[0] !== out_hash_value)
          note_mismatch("hash_value", hash_expected.pop_front(), out_hash_value);
        else
          void'(hash_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_beat(input logic [7:0] b, input logic present, input logic last,
                           input logic use_known, input logic [31:0] typed_hash);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_byte_present <= present;
    in_last         <= last;
    known_valid     <= use_known;
    known_hash      <= typed_hash;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // hold valid low until every hash is out and the datapath has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hash_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    seed_writes++;
  endtask

  task automatic random_messages(input int item_goal);
    int sent;
    int len;
    int pick;
    logic closed;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 10)
        len = 0;
      else if (pick < 80)
        len = $urandom_range(12, 1);
      else if (pick < 95)
        len = $urandom_range(40, 13);
      else
        len = $urandom_range(90, 41);
      closed = 1'b0;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0)
          send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 32'h0);
        closed = (i == len - 1) && ($urandom_range(9) < 7);
        send_beat(8'($urandom_range(255)), 1'b1, closed, 1'b0, 32'h0);
        sent++;
      end
      if (!closed) begin
        // close with an empty end marker; its byte lane carries junk
        send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 32'h0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_byte_present = 1'b0;
    in_last         = 1'b0;
    known_valid     = 1'b0;
    known_hash      = '0;
    gap_pct         = 25;
    stall_pct       = 75;
    mismatch_count  = 0;
    hash_checks     = 0;
    data_beats      = 0;
    messages        = 0;
    seed_writes     = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SEED) begin
        drain();
        write_seed(directed_rows[i].value);
      end else begin
        send_beat(directed_rows[i].data, directed_rows[i].present, directed_rows[i].last,
                  directed_rows[i].known, directed_rows[i].value);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      gap_pct   = (ph == 0) ? 25 : (ph == 1) ? 75 : 0;
      stall_pct = (ph == 0) ? 75 : (ph == 1) ? 25 : 0;
      case (ph)
        0: write_seed($urandom);
        1: write_seed(32'h80000001);
        default: write_seed(32'h7fffffff);
      endcase
      random_messages(PHASE_ITEMS / 2);
      drain();
      write_seed((ph == 2) ? 32'h00000000 : $urandom);
      random_messages(PHASE_ITEMS / 2);
    end
    drain();

    if (hash_expected.size() != 0)
      note_mismatch("hash never arrived", hash_expected[0], 32'h0);

    $display("Run covered %0d data beats in %0d messages across %0d seed settings,",
             data_beats, messages, seed_writes + 1);
    $display("%0d hashes checked, %0d mismatches, %0d cycles",
             hash_checks, mismatch_count, cycle_count);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mm3_pkg.sv
sv/mm3_datapath.sv
sv/mm3_ctrl.sv
sv/murmur3_32_hash_core.sv
sim/tb.sv
